### src/mrfc_pkg.sv
package mrfc_pkg;

  localparam logic [1:0] KIND_ID     = 2'd0;
  localparam logic [1:0] KIND_FUNC   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_CRC   = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG  = 2'd2;
  localparam logic [1:0] STAT_TOO_SHORT = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int          COUNT_W        = 9;
  localparam logic [8:0]  COUNT_SAT      = 9'd511;
  localparam logic [8:0]  MIN_FRAME      = 9'd4;
  localparam logic [8:0]  CRC_BYTES      = 9'd2;
  localparam logic [7:0]  MAX_DATA_RESET = 8'd252;

  // result queue depth, at least two
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/mrfc_core.sv
module mrfc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 frame_end,
  input  logic [7:0]           max_data,
  output mrfc_pkg::push_t      push
);

  logic [15:0] crc_accum;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [mrfc_pkg::COUNT_W-1:0] byte_count;

  logic [15:0] crc_next;
  logic [mrfc_pkg::COUNT_W-1:0] count_next;
  logic [mrfc_pkg::COUNT_W-1:0] tail;
  logic        emit;
  logic [1:0]  kind;
  logic [1:0]  st;
  mrfc_pkg::result_t byte_res;
  mrfc_pkg::result_t stat_res;

  always_comb begin
    emit = byte_count >= mrfc_pkg::CRC_BYTES;
    if (byte_count == mrfc_pkg::CRC_BYTES) begin
      kind = mrfc_pkg::KIND_ID;
    end else if (byte_count == mrfc_pkg::CRC_BYTES + 9'd1) begin
      kind = mrfc_pkg::KIND_FUNC;
    end else begin
      kind = mrfc_pkg::KIND_DATA;
    end
    crc_next   = emit ? mrfc_pkg::crc_fold(crc_accum, held0) : crc_accum;
    count_next = (byte_count == mrfc_pkg::COUNT_SAT) ? mrfc_pkg::COUNT_SAT
                                                     : byte_count + 9'd1;
    tail = count_next - mrfc_pkg::MIN_FRAME;

    // length short beats crc, crc beats data length
    if (count_next < mrfc_pkg::MIN_FRAME) begin
      st = mrfc_pkg::STAT_TOO_SHORT;
    end else if ({in_byte, held1} != crc_next) begin
      st = mrfc_pkg::STAT_BAD_CRC;
    end else if (tail > {1'b0, max_data}) begin
      st = mrfc_pkg::STAT_TOO_LONG;
    end else begin
      st = mrfc_pkg::STAT_OK;
    end

    byte_res = '{kind: kind, value: held0, status: mrfc_pkg::STAT_OK, last: 1'b0};
    stat_res = '{kind: mrfc_pkg::KIND_STATUS, value: 8'd0, status: st, last: 1'b1};

    push.n  = fire ? ({1'b0, emit} + {1'b0, frame_end}) : 2'd0;
    push.r0 = emit ? byte_res : stat_res;
    push.r1 = stat_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum  <= mrfc_pkg::CRC_INIT;
      held0      <= 8'd0;
      held1      <= 8'd0;
      byte_count <= '0;
    end else if (fire) begin
      if (frame_end) begin
        crc_accum  <= mrfc_pkg::CRC_INIT;
        held0      <= 8'd0;
        held1      <= 8'd0;
        byte_count <= '0;
      end else begin
        crc_accum  <= crc_next;
        held0      <= held1;
        held1      <= in_byte;
        byte_count <= count_next;
      end
    end
  end

endmodule

### src/mrfc_fifo.sv
module mrfc_fifo #(
  parameter int DEPTH = mrfc_pkg::RES_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  mrfc_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              not_empty,
  output mrfc_pkg::result_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrfc_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr1;
  logic [PTR_W-1:0] wr_ptr2;
  logic [PTR_W-1:0] rd_ptr1;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    wr_ptr1 = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    wr_ptr2 = (wr_ptr1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr1 + 1'b1;
    rd_ptr1 = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    case (push.n)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = wr_ptr2;
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CNT_W'(push.n) - CNT_W'(pop);
  end

  assign room      = count <= CNT_W'(DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
    end
  end

endmodule

### src/modbus_rtu_frame_checker_unit.sv
// Path: with the queue empty and the output ready, results pass the input register, then
//   the result queue; a status follows its frame's last byte when the final beat releases one.
// Throughput: one input beat per cycle while the queue has room, set by the combinational
//   byte CRC update; a final beat that releases a byte yields two output beats, and the
//   output side drains one per cycle while m_axis_tready is high.
// Reset: clears CRC, held bytes, count and result queue; max_data returns to 252.
module modbus_rtu_frame_checker_unit #(
  parameter int RES_DEPTH = mrfc_pkg::RES_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value, [9:8] status, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // max_data
);

  logic              in_vld;
  logic [7:0]        in_byte;
  logic              in_end;
  logic [7:0]        max_data;
  logic              room;
  logic              fire;
  logic              pop;
  mrfc_pkg::push_t   push;
  mrfc_pkg::result_t head;

  assign fire          = in_vld && room;
  assign s_axis_tready = !in_vld || fire;
  assign cfg_ready     = 1'b1;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      max_data <= mrfc_pkg::MAX_DATA_RESET;
    end else begin
      if (s_axis_tready) begin
        in_vld <= s_axis_tvalid;
      end
      if (cfg_valid && cfg_ready) begin
        max_data <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  mrfc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .in_byte   (in_byte),
    .frame_end (in_end),
    .max_data  (max_data),
    .push      (push)
  );

  mrfc_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (m_axis_tvalid),
    .head      (head)
  );

  assign m_axis_tdata = {6'd0, head.status, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // status beat and only the status beat closes the frame
  a_last_on_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tuser == mrfc_pkg::KIND_STATUS) == m_axis_tlast))
    else $error("tlast does not match status beat");

  a_byte_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != mrfc_pkg::KIND_STATUS) |-> m_axis_tdata[9:8] == 2'd0)
    else $error("byte beat carries a status");

  a_status_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == mrfc_pkg::KIND_STATUS) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("status beat carries a byte");

  a_double_push_on_end: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (fire && in_end && push.r1.last && !push.r0.last))
    else $error("two results pushed outside a frame end");

  a_push_needs_fire: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> fire)
    else $error("result pushed without an item");

endmodule
